// File: hw/rtl/interval_coverage_annotator_macros.svh
// Assertion macros shared by the interval coverage annotator checkers.
`ifndef INTERVAL_COVERAGE_ANNOTATOR_MACROS_SVH
`define INTERVAL_COVERAGE_ANNOTATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ICA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ICA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ica_pkg.sv
// Shared types, constants and command/status structures of the interval coverage annotator.
`default_nettype none

package ica_pkg;

    localparam int POS_W        = 16;
    localparam int POSITIONS    = 1 << POS_W;
    localparam int ADDR_W       = POS_W + 1;
    localparam int CNT_W        = 17;
    localparam int TRACKS       = 32;
    localparam int TRK_W        = 5;
    localparam int NTR_W        = 6;
    localparam int GENE_W       = 16;
    localparam int GENE_REPORTS = 31;
    localparam int ID_IDX_W     = 5;
    localparam int CHG_W        = 6;
    localparam int RES_W        = 7;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 40;
    localparam int CFG_DATA_W   = 6;

    localparam logic CFG_NUM_TRACKS = 1'b0;
    localparam logic CFG_GENE_EN    = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_PAINT = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_TRACK    = 2'd0,
        KIND_GENE_CNT = 2'd1,
        KIND_GENE_ID  = 2'd2
    } kind_t;

    typedef struct packed {
        logic load;
        logic walk;
        logic emit;
    } ica_cmd_t;

    typedef struct packed {
        logic walk_end;
        logic pipe_busy;
        logic out_free;
        logic is_query;
        logic res_none;
        logic res_last;
    } ica_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/interval_coverage_annotator.sv
// Top level of the interval coverage annotator: stream ports, controller and datapath.
//
//   Channel   Direction  Beat carries
//   s_axis    in         op (tuser); start_req, end_pos, track, gene_id (tdata)
//   m_axis    out        kind (tuser); track_res, count, gene_id_res, truncated (tdata); last
//   cfg       in         register index and write data
//
// After reset the block zeroes every position of both stores before it takes a beat.
// After its beat a clear keeps the input closed while it zeroes both stores again, a paint
// while it writes its gene id over the clamped interval, and a mark or a query until its
// walk over that interval and the registered read stage behind it have both finished.
// A query then sends one result beat per cycle while the output side takes them.
// Configuration writes are always taken; the output register holds a beat under stall.
`default_nettype none

module interval_coverage_annotator
    import ica_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // start_req, end_pos, track, gene_id, pad
    input  wire logic [1:0]            s_axis_tuser,  // op
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // track_res, count, gene_id_res, truncated, pad
    output logic [1:0]                 m_axis_tuser,  // kind
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ica_cmd_t          cmd;
    ica_sts_t          sts;
    logic [TRK_W-1:0]  out_track;
    logic [CNT_W-1:0]  out_count;
    logic [GENE_W-1:0] out_gene;
    logic              out_trunc;

    assign cfg_ready = 1'b1;

    ica_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ica_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_axis_tuser),
        .in_start  (s_axis_tdata[15:0]),
        .in_end    (s_axis_tdata[32:16]),
        .in_track  (s_axis_tdata[37:33]),
        .in_gene   (s_axis_tdata[53:38]),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_track (out_track),
        .out_count (out_count),
        .out_gene  (out_gene),
        .out_trunc (out_trunc),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_trunc, out_gene, out_count, out_track};

endmodule

`default_nettype wire

// File: hw/rtl/ica_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ica_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ica_ctrl.sv
// Controller state machine sequencing the clearing pass, interval walks and result beats.
`default_nettype none

module ica_ctrl
    import ica_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ica_sts_t sts,
    output ica_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_INIT = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_WALK = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_end && !sts.pipe_busy)
                begin
                    if (sts.is_query && !sts.res_none)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.res_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ica_dp.sv
// Datapath: configuration, interval walker, both stores, counters and the output register.
`default_nettype none

module ica_dp
    import ica_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ica_cmd_t              cmd,
    output ica_sts_t                   sts,
    input  wire logic [1:0]            in_op,
    input  wire logic [POS_W-1:0]      in_start,
    input  wire logic [ADDR_W-1:0]     in_end,
    input  wire logic [TRK_W-1:0]      in_track,
    input  wire logic [GENE_W-1:0]     in_gene,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_kind,
    output logic [TRK_W-1:0]           out_track,
    output logic [CNT_W-1:0]           out_count,
    output logic [GENE_W-1:0]          out_gene,
    output logic                       out_trunc,
    output logic                       out_last
);

    logic [NTR_W-1:0]  num_tracks_reg;
    logic              gene_en_reg;
    op_t               mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [TRK_W-1:0]  track_reg;
    logic [GENE_W-1:0] gene_reg;
    logic              p1_reg;
    logic [POS_W-1:0]  p1_addr_reg;
    logic [RES_W-1:0]  res_idx_reg;
    logic              out_valid_reg;

    logic [CNT_W-1:0]  trk_cnt_reg [TRACKS];
    logic [CNT_W-1:0]  gene_cnt_reg;
    logic [GENE_W-1:0] last_gene_reg;
    logic [CHG_W-1:0]  changes_reg;
    logic [GENE_W-1:0] ids_reg [GENE_REPORTS];

    logic [1:0]        out_kind_reg;
    logic [TRK_W-1:0]  out_track_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [GENE_W-1:0] out_gene_reg;
    logic              out_trunc_reg;
    logic              out_last_reg;

    logic [ADDR_W-1:0] end_cl;
    logic [ADDR_W-1:0] start_cl;
    logic              issue;
    logic              p1_next;
    logic              trk_we;
    logic [TRACKS-1:0] trk_wdata;
    logic              trk_re;
    logic [TRACKS-1:0] trk_rdata;
    logic              gene_we;
    logic [GENE_W-1:0] gene_wdata;
    logic              gene_re;
    logic [GENE_W-1:0] gene_rdata;
    logic [POS_W-1:0]  trk_waddr;
    logic [NTR_W-1:0]  ntr;
    logic              trunc;
    logic [CHG_W-1:0]  nrep;
    logic [RES_W-1:0]  total;
    logic [RES_W-1:0]  rel_idx;
    logic              out_take;

    assign end_cl   = (in_end > ADDR_W'(POSITIONS)) ? ADDR_W'(POSITIONS) : in_end;
    assign start_cl = ({1'b0, in_start} > end_cl) ? end_cl : {1'b0, in_start};

    assign issue   = cmd.walk && (addr_reg != end_reg);
    assign p1_next = issue && ((mode_reg == OP_MARK) || (mode_reg == OP_QUERY));

    always_comb
    begin
        trk_we     = 1'b0;
        trk_waddr  = addr_reg[POS_W-1:0];
        trk_wdata  = '0;
        trk_re     = 1'b0;
        gene_we    = 1'b0;
        gene_wdata = '0;
        gene_re    = 1'b0;
        case (mode_reg)
            OP_CLEAR:
            begin
                trk_we  = issue;
                gene_we = issue;
            end
            OP_MARK:
            begin
                trk_re    = issue;
                trk_we    = p1_reg;
                trk_waddr = p1_addr_reg;
                trk_wdata = trk_rdata | (TRACKS'(1) << track_reg);
            end
            OP_PAINT:
            begin
                gene_we    = issue;
                gene_wdata = gene_reg;
            end
            OP_QUERY:
            begin
                trk_re  = issue;
                gene_re = issue;
            end
            default:
            begin
                trk_we = 1'b0;
            end
        endcase
    end

    ica_ram #(
        .WIDTH (TRACKS),
        .DEPTH (POSITIONS)
    ) u_track_ram (
        .clk   (clk),
        .we    (trk_we),
        .waddr (trk_waddr),
        .wdata (trk_wdata),
        .re    (trk_re),
        .raddr (addr_reg[POS_W-1:0]),
        .rdata (trk_rdata)
    );

    ica_ram #(
        .WIDTH (GENE_W),
        .DEPTH (POSITIONS)
    ) u_gene_ram (
        .clk   (clk),
        .we    (gene_we),
        .waddr (addr_reg[POS_W-1:0]),
        .wdata (gene_wdata),
        .re    (gene_re),
        .raddr (addr_reg[POS_W-1:0]),
        .rdata (gene_rdata)
    );

    assign ntr     = (num_tracks_reg > NTR_W'(TRACKS)) ? NTR_W'(TRACKS) : num_tracks_reg;
    assign trunc   = changes_reg > CHG_W'(GENE_REPORTS);
    assign nrep    = trunc ? CHG_W'(GENE_REPORTS) : changes_reg;
    assign total   = RES_W'(ntr) + (gene_en_reg ? (RES_W'(nrep) + RES_W'(1)) : RES_W'(0));
    assign rel_idx = RES_W'(res_idx_reg - RES_W'(ntr) - RES_W'(1));
    assign out_take = out_valid_reg && out_ready;

    assign sts.walk_end  = (addr_reg == end_reg);
    assign sts.pipe_busy = p1_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.is_query  = (mode_reg == OP_QUERY);
    assign sts.res_none  = (total == '0);
    assign sts.res_last  = (res_idx_reg == RES_W'(total - RES_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tracks_reg <= NTR_W'(1);
            gene_en_reg    <= 1'b0;
            mode_reg       <= OP_CLEAR;
            addr_reg       <= '0;
            end_reg        <= ADDR_W'(POSITIONS);
            p1_reg         <= 1'b0;
            res_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_NUM_TRACKS: num_tracks_reg <= cfg_wdata;
                    CFG_GENE_EN:    gene_en_reg    <= cfg_wdata[0];
                    default:        gene_en_reg    <= gene_en_reg;
                endcase
            end
            p1_reg <= p1_next;
            if (cmd.load)
            begin
                mode_reg    <= op_t'(in_op);
                res_idx_reg <= '0;
                if (op_t'(in_op) == OP_CLEAR)
                begin
                    addr_reg <= '0;
                    end_reg  <= ADDR_W'(POSITIONS);
                end
                else
                begin
                    addr_reg <= start_cl;
                    end_reg  <= end_cl;
                end
            end
            else if (issue)
            begin
                addr_reg <= ADDR_W'(addr_reg + ADDR_W'(1));
            end
            if (cmd.emit)
            begin
                res_idx_reg   <= RES_W'(res_idx_reg + RES_W'(1));
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            track_reg     <= in_track;
            gene_reg      <= in_gene;
            gene_cnt_reg  <= '0;
            last_gene_reg <= '0;
            changes_reg   <= '0;
            for (int j = 0; j < TRACKS; j++)
            begin
                trk_cnt_reg[j] <= '0;
            end
        end
        if (issue)
        begin
            p1_addr_reg <= addr_reg[POS_W-1:0];
        end
        if (p1_reg && (mode_reg == OP_QUERY))
        begin
            for (int j = 0; j < TRACKS; j++)
            begin
                if (trk_rdata[j])
                begin
                    trk_cnt_reg[j] <= CNT_W'(trk_cnt_reg[j] + CNT_W'(1));
                end
            end
            if (gene_rdata != '0)
            begin
                gene_cnt_reg <= CNT_W'(gene_cnt_reg + CNT_W'(1));
                if (gene_rdata != last_gene_reg)
                begin
                    last_gene_reg <= gene_rdata;
                    if (changes_reg < CHG_W'(GENE_REPORTS))
                    begin
                        ids_reg[changes_reg[ID_IDX_W-1:0]] <= gene_rdata;
                    end
                    if (changes_reg <= CHG_W'(GENE_REPORTS))
                    begin
                        changes_reg <= CHG_W'(changes_reg + CHG_W'(1));
                    end
                end
            end
        end
        if (cmd.emit)
        begin
            out_last_reg <= sts.res_last;
            if (res_idx_reg < RES_W'(ntr))
            begin
                out_kind_reg  <= KIND_TRACK;
                out_track_reg <= res_idx_reg[TRK_W-1:0];
                out_count_reg <= trk_cnt_reg[res_idx_reg[TRK_W-1:0]];
                out_gene_reg  <= '0;
                out_trunc_reg <= 1'b0;
            end
            else if (res_idx_reg == RES_W'(ntr))
            begin
                out_kind_reg  <= KIND_GENE_CNT;
                out_track_reg <= '0;
                out_count_reg <= gene_cnt_reg;
                out_gene_reg  <= '0;
                out_trunc_reg <= trunc;
            end
            else
            begin
                out_kind_reg  <= KIND_GENE_ID;
                out_track_reg <= '0;
                out_count_reg <= '0;
                out_gene_reg  <= ids_reg[rel_idx[ID_IDX_W-1:0]];
                out_trunc_reg <= trunc;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_track = out_track_reg;
    assign out_count = out_count_reg;
    assign out_gene  = out_gene_reg;
    assign out_trunc = out_trunc_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ica_checker.sv
// Port-level assertion checker for the interval coverage annotator, bound to the top level.
`default_nettype none

`include "interval_coverage_annotator_macros.svh"

module ica_checker
    import ica_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]            m_axis_tuser,
    input wire logic                  m_axis_tlast
);

    logic                  in_take;
    logic                  out_stall;
    logic                  track_beat;
    logic                  id_beat;
    logic [OUT_DATA_W+2:0] out_beat;

    assign in_take    = s_axis_tvalid && s_axis_tready;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign track_beat = m_axis_tvalid && (m_axis_tuser == KIND_TRACK);
    assign id_beat    = m_axis_tvalid && (m_axis_tuser == KIND_GENE_ID);
    assign out_beat   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    `ICA_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_beat),
                     "Result beat changed while stalled.")
    `ICA_ASSERT_NEXT(a_one_item, in_take, !s_axis_tready,
                     "A second item was taken while one was at work.")
    `ICA_ASSERT_NOW(a_track_clean, track_beat, m_axis_tdata[38:22] == 17'd0,
                    "Track count beat carries gene fields.")
    `ICA_ASSERT_NOW(a_id_clean, id_beat,
                    (m_axis_tdata[21:5] == 17'd0) && (m_axis_tdata[37:22] != 16'd0),
                    "Gene id beat has a count or a zero id.")

endmodule

bind interval_coverage_annotator ica_checker u_ica_checker (.*);

`default_nettype wire
